### rtl/smd_pkg.sv
package smd_pkg;

  // Fixed-point format of all spectral parts
  localparam int FRAC_BITS = 16;

  // Divider cells: one integer quotient bit plus the fraction bits
  localparam int NCELL = FRAC_BITS + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int DEN_W = 64;
  localparam int REM_W = DEN_W + 1;

  // Front pipeline depth and total start-to-strobe latency
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + NCELL + 1;

  // Quotient limit 1.00001 as squares: anorm*1e10 > den*(1e10 + 200001)
  localparam logic [33:0] CLAMP_DEN  = 34'd10000000000;
  localparam logic [17:0] CLAMP_EXCS = 18'd200001;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_FLOOR = 2'd1;

  // Per-item control that rides along the divider chain
  typedef struct packed {
    logic        valid;
    logic        divide;
    logic        last;
    logic        too_small;
    logic        clamped;
    logic        sat;
    logic        neg_re;
    logic        neg_im;
    logic [31:0] mul_re;
    logic [31:0] mul_im;
  } smd_tag_t;

  // One beat moving from cell to cell
  typedef struct packed {
    smd_tag_t          tag;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [DEN_W-1:0]  den;
    logic [QW-1:0]     q_re;
    logic [QW-1:0]     q_im;
  } smd_div_t;

  // Sign and magnitude to 32-bit two's complement, saturating; {sat, value}
  function automatic logic [32:0] smd_pack(logic neg, logic [63:0] m);
    logic [31:0] v;
    logic        s;
    s = 1'b0;
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) begin
        s = 1'b1;
        v = 32'h7FFF_FFFF;
      end else begin
        v = m[31:0];
      end
    end else begin
      if (m > 64'h8000_0000) begin
        s = 1'b1;
        v = 32'h8000_0000;
      end else begin
        v = 32'(~m[31:0] + 32'd1);
      end
    end
    return {s, v};
  endfunction

endpackage

### rtl/spectral_multiply_divide.sv
// Pipeline: a result strobes once the item accepted with start has passed
// the four front stages, seventeen divider cells and one output register.
// Throughput: one item per cycle; busy stays low, the row of divider cells
// takes a new beat every cycle. The receiver cannot stall.
// Reset (synchronous, rst_n low): pipeline emptied, mode = multiply,
// divisor floor = 1.
module spectral_multiply_divide import smd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic               in_last_point,
  output logic               out_valid,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im,
  output logic               out_divisor_too_small,
  output logic               out_quotient_clamped,
  output logic               out_saturated,
  output logic               out_last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic        mode_r;
  logic [30:0] floor_r;
  logic        acc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      floor_r <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_FLOOR: floor_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  smd_div_t chain [0:NCELL];

  smd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .a_re       (in_a_re),
    .a_im       (in_a_im),
    .b_re       (in_b_re),
    .b_im       (in_b_im),
    .last_point (in_last_point),
    .mode_divide(mode_r),
    .min_mag    (floor_r),
    .div_o      (chain[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    smd_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_i  (chain[g]),
      .d_o  (chain[g+1])
    );
  end

  // Select final result
  smd_div_t    fin;
  logic [32:0] q_re_pk, q_im_pk;
  logic        vld_nxt, small_nxt, clamp_nxt, sat_nxt, last_nxt;
  logic [31:0] re_nxt, im_nxt;
  logic        vld_r, small_r, clamp_r, sat_r, last_r;
  logic [31:0] re_r, im_r;

  always_comb begin
    fin       = chain[NCELL];
    q_re_pk   = smd_pack(fin.tag.neg_re, 64'(fin.q_re));
    q_im_pk   = smd_pack(fin.tag.neg_im, 64'(fin.q_im));
    vld_nxt   = fin.tag.valid;
    last_nxt  = fin.tag.last;
    small_nxt = fin.tag.too_small;
    clamp_nxt = fin.tag.clamped;
    sat_nxt   = fin.tag.sat;
    if (!fin.tag.divide) begin
      re_nxt = fin.tag.mul_re;
      im_nxt = fin.tag.mul_im;
    end else if (fin.tag.too_small || fin.tag.clamped) begin
      re_nxt = '0;
      im_nxt = '0;
    end else begin
      re_nxt = q_re_pk[31:0];
      im_nxt = q_im_pk[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    re_r    <= re_nxt;
    im_r    <= im_nxt;
    small_r <= small_nxt;
    clamp_r <= clamp_nxt;
    sat_r   <= sat_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid             = vld_r;
  assign out_re                = re_r;
  assign out_im                = im_r;
  assign out_divisor_too_small = small_r;
  assign out_quotient_clamped  = clamp_r;
  assign out_saturated         = sat_r;
  assign out_last_out          = last_r;

  // Checks
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_divisor_too_small && out_quotient_clamped))
    else $error("divide flags both set");

  a_sat_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> !out_divisor_too_small && !out_quotient_clamped)
    else $error("saturation flag in divide mode");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor_too_small || out_quotient_clamped)
      |-> out_re == '0 && out_im == '0)
    else $error("forced-zero result not zero");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("result strobe missing");

endmodule

### rtl/smd_front.sv
module smd_front import smd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  input  logic                last_point,
  input  logic                mode_divide,
  input  logic [30:0]         min_mag,
  output smd_div_t            div_o
);

  // Stage 1: products
  logic               v1_r, last1_r, div1_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [63:0] p_br_r, p_bi_r, p_ar_r, p_ai_r;
  logic [61:0]        f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    last1_r <= last_point;
    div1_r  <= mode_divide;
    p_rr_r  <= a_re * b_re;
    p_ii_r  <= a_im * b_im;
    p_ir_r  <= a_im * b_re;
    p_ri_r  <= a_re * b_im;
    p_br_r  <= b_re * b_re;
    p_bi_r  <= b_im * b_im;
    p_ar_r  <= a_re * a_re;
    p_ai_r  <= a_im * a_im;
    f2_r    <= min_mag * min_mag;
  end

  // Stage 2: sums, sign/magnitude, multiply result, divisor floor test
  logic signed [65:0] re_s, im_s;
  logic [65:0]        re_abs, im_abs;
  logic [63:0]        den_c, an_c;
  logic [32:0]        pk_re, pk_im;
  smd_tag_t           tag2_nxt, tag2_r;
  logic [63:0]        mag_re2_r, mag_im2_r, den2_r, diff2_r;
  logic               agt2_r;

  always_comb begin
    if (div1_r) begin
      re_s = 66'(p_rr_r) + 66'(p_ii_r);
      im_s = 66'(p_ir_r) - 66'(p_ri_r);
    end else begin
      re_s = 66'(p_rr_r) - 66'(p_ii_r);
      im_s = 66'(p_ir_r) + 66'(p_ri_r);
    end
    re_abs = re_s[65] ? 66'(-re_s) : 66'(re_s);
    im_abs = im_s[65] ? 66'(-im_s) : 66'(im_s);
    den_c  = 64'(p_br_r) + 64'(p_bi_r);
    an_c   = 64'(p_ar_r) + 64'(p_ai_r);
    pk_re  = smd_pack(re_s[65], re_abs[63:0] >> FRAC_BITS);
    pk_im  = smd_pack(im_s[65], im_abs[63:0] >> FRAC_BITS);

    tag2_nxt           = '0;
    tag2_nxt.valid     = v1_r;
    tag2_nxt.divide    = div1_r;
    tag2_nxt.last      = last1_r;
    tag2_nxt.too_small = div1_r && (den_c <= 64'(f2_r));
    tag2_nxt.sat       = !div1_r && (pk_re[32] || pk_im[32]);
    tag2_nxt.neg_re    = re_s[65];
    tag2_nxt.neg_im    = im_s[65];
    tag2_nxt.mul_re    = pk_re[31:0];
    tag2_nxt.mul_im    = pk_im[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r <= tag2_nxt;
    end
    mag_re2_r <= re_abs[63:0];
    mag_im2_r <= im_abs[63:0];
    den2_r    <= den_c;
    diff2_r   <= an_c - den_c;
    agt2_r    <= an_c > den_c;
  end

  // Stage 3: partial products of the quotient limit test
  smd_tag_t    tag3_r;
  logic [63:0] mag_re3_r, mag_im3_r, den3_r;
  logic        agt3_r;
  logic [65:0] l_lo_r, l_hi_r;
  logic [49:0] r_lo_r, r_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
    end else begin
      tag3_r <= tag2_r;
    end
    mag_re3_r <= mag_re2_r;
    mag_im3_r <= mag_im2_r;
    den3_r    <= den2_r;
    agt3_r    <= agt2_r;
    l_lo_r    <= diff2_r[31:0] * CLAMP_DEN;
    l_hi_r    <= diff2_r[63:32] * CLAMP_DEN;
    r_lo_r    <= den2_r[31:0] * CLAMP_EXCS;
    r_hi_r    <= den2_r[63:32] * CLAMP_EXCS;
  end

  // Stage 4: combine partials, load the divider beat
  logic [97:0] lhs, rhs;
  smd_div_t    div_nxt, div_r;

  always_comb begin
    lhs = 98'(l_lo_r) + (98'(l_hi_r) << 32);
    rhs = 98'(r_lo_r) + (98'(r_hi_r) << 32);
    div_nxt             = '0;
    div_nxt.tag         = tag3_r;
    div_nxt.tag.clamped = tag3_r.divide && !tag3_r.too_small && agt3_r && (lhs > rhs);
    div_nxt.rem_re      = REM_W'(mag_re3_r);
    div_nxt.rem_im      = REM_W'(mag_im3_r);
    div_nxt.den         = den3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

### rtl/smd_cell.sv
module smd_cell import smd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  smd_div_t d_i,
  output smd_div_t d_o
);

  // One restoring step per component: subtract if it fits, shift remainder
  logic [REM_W-1:0] den_x, r_re, r_im;
  logic             ge_re, ge_im;
  smd_div_t         d_nxt, d_r;

  always_comb begin
    den_x = REM_W'(d_i.den);
    ge_re = d_i.rem_re >= den_x;
    ge_im = d_i.rem_im >= den_x;
    r_re  = ge_re ? d_i.rem_re - den_x : d_i.rem_re;
    r_im  = ge_im ? d_i.rem_im - den_x : d_i.rem_im;
    d_nxt        = d_i;
    d_nxt.rem_re = {r_re[REM_W-2:0], 1'b0};
    d_nxt.rem_im = {r_im[REM_W-2:0], 1'b0};
    d_nxt.q_re   = {d_i.q_re[QW-2:0], ge_re};
    d_nxt.q_im   = {d_i.q_im[QW-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
